FILE: hw/rtl/bsc_pkg.sv
package bsc_pkg;

  localparam int MAX_PATTERN_DEF = 256;
  localparam int FRAC_BITS_DEF   = 32;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 18;

  localparam int FRAME_W   = 16;
  localparam int TEMPO_W   = 17;
  localparam int RATE_W    = 18;
  localparam int SWING_W   = 16;
  localparam int PLEN_W    = 9;
  localparam int SAMPLE_W  = 48;
  localparam int STEP_OUT_W = 8;
  localparam int WHOLE_W   = 32;

  localparam int PROD_W     = FRAME_W + TEMPO_W;
  localparam int DEN_W      = 32;
  localparam int ABS_STEP_W = WHOLE_W + 2;
  localparam int THR_W      = 19;

  localparam logic [TEMPO_W-1:0] TEMPO_RST = 17'd30720;
  localparam logic [RATE_W-1:0]  RATE_RST  = 18'd44100;
  localparam logic [SWING_W-1:0] SWING_RST = 16'd0;
  localparam logic [PLEN_W-1:0]  PLEN_RST  = 9'd16;

  // swing thresholds in units of 1/393216 beat, before adding swing
  localparam logic [THR_W-1:0] THR1_BASE = 19'd98304;
  localparam logic [THR_W-1:0] THR3_BASE = 19'd294912;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_RUN_ENABLE     = 3'd0,
    CFG_TEMPO_Q8       = 3'd1,
    CFG_SAMPLE_RATE_HZ = 3'd2,
    CFG_SWING_Q16      = 3'd3,
    CFG_PATTERN_STEPS  = 3'd4
  } bsc_cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV_INC,
    S_ADD,
    S_STEP,
    S_MOD_START,
    S_DIV_MOD,
    S_FIN
  } bsc_state_t;

  typedef struct packed {
    logic capture;
    logic start_inc;
    logic add;
    logic step;
    logic start_mod;
    logic finish;
  } bsc_cmd_t;

  typedef struct packed {
    logic active;
    logic div_busy;
    logic out_free;
  } bsc_status_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_count;
  } bsc_in_item_t;

  typedef struct packed {
    logic                  step_changed;
    logic [STEP_OUT_W-1:0] step_index;
    logic                  pattern_wrapped;
    logic [SAMPLE_W-1:0]   samples_played;
  } bsc_out_item_t;

endpackage

FILE: hw/rtl/bsc_stream_if.sv
interface bsc_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/bpm_swing_step_clock_top.sv
// Tempo clock for a sixteenth-note step sequencer with swing.
// in_item carries one audio buffer's frame count per request; out_item returns
// exactly one result per request: step_changed, step_index, pattern_wrapped and
// samples_played. Both channels use valid/ready. Registers must be written through
// cfg_wr_en/cfg_addr/cfg_wdata only while no request is in flight; the block does not enforce this.
// A request while stopped or with a zero pattern length skips the divider. One
// request is in flight at a time and the next one is accepted on the cycle after
// the result is committed. A running request uses the shared serial divider
// twice: over 33 + FRAC_BITS dividend bits for the beat increment, then over 34
// bits for the step modulo.
// The result sits in an output register; a new request is accepted while an
// earlier result still waits, and only the final commit stalls on out_item.ready.
// Reset (rst_n low, synchronous) stops the transport, loads the default tempo,
// rate, swing and pattern length, and clears beat, step, wrap flag and sample
// count; the block is ready on the first cycle after reset.
module bpm_swing_step_clock_top #(
  parameter int MAX_PATTERN = bsc_pkg::MAX_PATTERN_DEF,
  parameter int FRAC_BITS   = bsc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [bsc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  bsc_stream_if.sink                     in_item,
  bsc_stream_if.source                   out_item
);

  bsc_pkg::bsc_cmd_t      cmd;
  bsc_pkg::bsc_status_t   st;
  bsc_pkg::bsc_out_item_t out_data;
  logic                   out_valid;
  logic                   in_ready;

  bsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  bsc_datapath #(
    .MAX_PATTERN (MAX_PATTERN),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .frame_count (in_item.data.frame_count),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_ready   (out_item.ready),
    .out_data    (out_data)
  );

  assign in_item.ready  = in_ready;
  assign out_item.valid = out_valid;
  assign out_item.data  = out_data;

endmodule

FILE: hw/rtl/bsc_divider.sv
module bsc_divider #(
  parameter int DW = 65,
  parameter int VW = 32,
  localparam int CW = $clog2(DW + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  input  logic [CW-1:0] count,
  output logic          busy,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dq_r, dq_nxt;
  logic [VW-1:0] dsor_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  // one restoring step per cycle
  always_comb begin
    trial   = {rem_r, dq_r[DW-1]};
    diff    = trial - {1'b0, dsor_r};
    ge      = trial >= {1'b0, dsor_r};
    rem_nxt = ge ? diff[VW-1:0] : trial[VW-1:0];
    dq_nxt  = {dq_r[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= count;
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      dq_r   <= dividend;
      dsor_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign busy      = busy_r;
  assign quotient  = dq_r;
  assign remainder = rem_r;

endmodule

FILE: hw/rtl/bsc_datapath.sv
module bsc_datapath #(
  parameter int MAX_PATTERN = bsc_pkg::MAX_PATTERN_DEF,
  parameter int FRAC_BITS   = bsc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [bsc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [bsc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [bsc_pkg::FRAME_W-1:0]       frame_count,
  input  bsc_pkg::bsc_cmd_t                 cmd,
  output bsc_pkg::bsc_status_t              st,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bsc_pkg::bsc_out_item_t            out_data
);

  localparam int LEN_CAP = (MAX_PATTERN < 511) ? MAX_PATTERN : 511;
  localparam int STEP_W  = $clog2(LEN_CAP);
  localparam int INC_W   = bsc_pkg::WHOLE_W + FRAC_BITS;
  localparam int DW      = bsc_pkg::PROD_W + FRAC_BITS;
  localparam int CW      = $clog2(DW + 1);
  localparam int LHS_W   = FRAC_BITS + bsc_pkg::THR_W;

  // configuration
  logic                          run_r;
  logic [bsc_pkg::TEMPO_W-1:0]   tempo_r;
  logic [bsc_pkg::RATE_W-1:0]    rate_r;
  logic [bsc_pkg::SWING_W-1:0]   swing_r;
  logic [bsc_pkg::PLEN_W-1:0]    plen_r;

  // per request
  logic [bsc_pkg::FRAME_W-1:0]   frames_r;
  logic [bsc_pkg::PROD_W-1:0]    prod_r;
  logic [bsc_pkg::DEN_W-1:0]     den_r;
  logic                          active_r;
  logic [bsc_pkg::PLEN_W-1:0]    len_r;
  logic [bsc_pkg::ABS_STEP_W-1:0] abs_r;

  // clock state
  logic [INC_W-1:0]              beat_r, beat_nxt;
  logic [bsc_pkg::SAMPLE_W-1:0]  sample_r, sample_nxt;
  logic [STEP_W-1:0]             step_r, step_nxt;
  logic                          wrap_r, wrap_nxt;
  logic                          changed;

  bsc_pkg::bsc_out_item_t        out_r;
  logic                          out_valid_r;

  logic [bsc_pkg::PLEN_W-1:0]    len_eff;
  logic [bsc_pkg::RATE_W-1:0]    rate_eff;
  logic [bsc_pkg::DEN_W-1:0]     rate32;
  logic [bsc_pkg::DEN_W-1:0]     den;

  logic                          div_start;
  logic [DW-1:0]                 div_dividend;
  logic [bsc_pkg::DEN_W-1:0]     div_divisor;
  logic [CW-1:0]                 div_count;
  logic                          div_busy;
  logic [DW-1:0]                 div_quo;
  logic [bsc_pkg::DEN_W-1:0]     div_rem;

  logic [FRAC_BITS-1:0]          frac;
  logic [FRAC_BITS+2:0]          frac6;
  logic [LHS_W-1:0]              lhs;
  logic [bsc_pkg::THR_W-1:0]     thr1;
  logic [bsc_pkg::THR_W-1:0]     thr3;
  logic [1:0]                    sib;
  logic [STEP_W-1:0]             mod_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      tempo_r <= bsc_pkg::TEMPO_RST;
      rate_r  <= bsc_pkg::RATE_RST;
      swing_r <= bsc_pkg::SWING_RST;
      plen_r  <= bsc_pkg::PLEN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        bsc_pkg::CFG_RUN_ENABLE:     run_r   <= cfg_wdata[0];
        bsc_pkg::CFG_TEMPO_Q8:       tempo_r <= cfg_wdata[bsc_pkg::TEMPO_W-1:0];
        bsc_pkg::CFG_SAMPLE_RATE_HZ: rate_r  <= cfg_wdata[bsc_pkg::RATE_W-1:0];
        bsc_pkg::CFG_SWING_Q16:      swing_r <= cfg_wdata[bsc_pkg::SWING_W-1:0];
        bsc_pkg::CFG_PATTERN_STEPS:  plen_r  <= cfg_wdata[bsc_pkg::PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // denominator 15360 * rate as (rate * 15) << 10
  always_comb begin
    len_eff  = (plen_r > bsc_pkg::PLEN_W'(LEN_CAP)) ? bsc_pkg::PLEN_W'(LEN_CAP) : plen_r;
    rate_eff = (rate_r == '0) ? bsc_pkg::RATE_W'(1) : rate_r;
    rate32   = bsc_pkg::DEN_W'(rate_eff);
    den      = ((rate32 << 4) - rate32) << 10;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      frames_r <= frame_count;
      prod_r   <= bsc_pkg::PROD_W'(frame_count) * bsc_pkg::PROD_W'(tempo_r);
      den_r    <= den;
      len_r    <= len_eff;
    end
    if (cmd.step) begin
      abs_r <= {beat_r[INC_W-1:FRAC_BITS], sib};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (cmd.capture) begin
      active_r <= run_r && (len_eff != '0);
    end
  end

  always_comb begin
    div_start    = cmd.start_inc || cmd.start_mod;
    div_dividend = cmd.start_inc ? {prod_r, {FRAC_BITS{1'b0}}}
                                 : {abs_r, {(DW - bsc_pkg::ABS_STEP_W){1'b0}}};
    div_divisor  = cmd.start_inc ? den_r : bsc_pkg::DEN_W'(len_r);
    div_count    = cmd.start_inc ? CW'(DW) : CW'(bsc_pkg::ABS_STEP_W);
  end

  bsc_divider #(
    .DW (DW),
    .VW (bsc_pkg::DEN_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .count     (div_count),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // step within the beat, odd boundaries delayed by swing
  always_comb begin
    frac  = beat_r[FRAC_BITS-1:0];
    frac6 = ({3'b000, frac} << 2) + ({3'b000, frac} << 1);
    lhs   = {frac6, 16'h0000};
    thr1  = bsc_pkg::THR1_BASE + bsc_pkg::THR_W'(swing_r);
    thr3  = bsc_pkg::THR3_BASE + bsc_pkg::THR_W'(swing_r);
    if (lhs < {thr1, {FRAC_BITS{1'b0}}}) begin
      sib = 2'd0;
    end else if (!frac[FRAC_BITS-1]) begin
      sib = 2'd1;
    end else if (lhs < {thr3, {FRAC_BITS{1'b0}}}) begin
      sib = 2'd2;
    end else begin
      sib = 2'd3;
    end
  end

  always_comb begin
    beat_nxt   = beat_r;
    sample_nxt = sample_r;
    step_nxt   = step_r;
    wrap_nxt   = wrap_r;
    mod_step   = div_rem[STEP_W-1:0];
    changed    = active_r && (mod_step != step_r);
    if (cmd.add) begin
      beat_nxt   = beat_r + div_quo[INC_W-1:0];
      sample_nxt = sample_r + bsc_pkg::SAMPLE_W'(frames_r);
    end
    if (cmd.finish && active_r) begin
      step_nxt = mod_step;
      wrap_nxt = wrap_r || (changed && (mod_step == '0));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r   <= '0;
      sample_r <= '0;
      step_r   <= '0;
      wrap_r   <= 1'b0;
    end else begin
      beat_r   <= beat_nxt;
      sample_r <= sample_nxt;
      step_r   <= step_nxt;
      wrap_r   <= wrap_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r.step_changed    <= changed;
      out_r.step_index      <= bsc_pkg::STEP_OUT_W'(step_nxt);
      out_r.pattern_wrapped <= wrap_nxt;
      out_r.samples_played  <= sample_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_data    = out_r;
  assign st.active   = active_r;
  assign st.div_busy = div_busy;
  assign st.out_free = !out_valid_r || out_ready;

  a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start_inc || cmd.start_mod) |-> !div_busy)
    else $error("divider started while busy");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && active_r) |=> (bsc_pkg::PLEN_W'(step_r) < len_r))
    else $error("step index not below pattern length");

  a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    wrap_r |=> wrap_r)
    else $error("wrap flag cleared outside reset");

  a_samples_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.add |=> $stable(sample_r))
    else $error("sample total moved without an add");

endmodule

FILE: hw/rtl/bsc_ctrl.sv
module bsc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bsc_pkg::bsc_status_t st,
  output bsc_pkg::bsc_cmd_t    cmd
);

  bsc_pkg::bsc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      bsc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = bsc_pkg::S_PREP;
        end
      end
      bsc_pkg::S_PREP: begin
        if (st.active) begin
          cmd.start_inc = 1'b1;
          state_nxt     = bsc_pkg::S_DIV_INC;
        end else begin
          state_nxt = bsc_pkg::S_FIN;
        end
      end
      bsc_pkg::S_DIV_INC: begin
        if (!st.div_busy) begin
          state_nxt = bsc_pkg::S_ADD;
        end
      end
      bsc_pkg::S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = bsc_pkg::S_STEP;
      end
      bsc_pkg::S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = bsc_pkg::S_MOD_START;
      end
      bsc_pkg::S_MOD_START: begin
        cmd.start_mod = 1'b1;
        state_nxt     = bsc_pkg::S_DIV_MOD;
      end
      bsc_pkg::S_DIV_MOD: begin
        if (!st.div_busy) begin
          state_nxt = bsc_pkg::S_FIN;
        end
      end
      bsc_pkg::S_FIN: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = bsc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bsc_pkg::S_IDLE;
      end
    endcase
  end

endmodule
